// ===== src/ncr_pkg.sv =====
package ncr_pkg;

	localparam int MAX_PROFILES = 5;
	localparam int NUM_TAGS = 5;
	localparam int ACTIVE_MAX = (MAX_PROFILES < NUM_TAGS) ? MAX_PROFILES : NUM_TAGS;

	localparam int TAG_W = 32;
	localparam int LEVEL_W = 8;
	localparam int COUNT_W = 3;
	localparam int OUT_IDX_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int IDX_W = (MAX_PROFILES > 1) ? $clog2(MAX_PROFILES) : 1;
	// seen flag on top of a 9-bit biased score
	localparam int KEY_W = 10;

	// command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_REPORT = 2'd1;
	localparam logic [1:0] CMD_EMIT = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	// register indexes
	localparam int REG_COUNT = 0;
	localparam int REG_TAG0 = 1;

	typedef struct packed {
		logic [1:0] command;
		logic [TAG_W-1:0] network_tag;
		logic signed [LEVEL_W-1:0] signal_level;
	} in_req_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] prof_pos;
		logic is_seen;
		logic last;
		logic empty_res;
	} out_res_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [1:0] op;
		logic [MAX_PROFILES-1:0] hit;
		logic signed [LEVEL_W-1:0] level;
	} job_t;

	typedef logic [MAX_PROFILES-1:0][TAG_W-1:0] tag_vec_t;

	function automatic logic [3:0] recency_bonus(input int pos);
		logic [3:0] b;
		case (pos)
			0: b = 4'd12;
			1: b = 4'd6;
			2: b = 4'd3;
			3: b = 4'd1;
			default: b = 4'd0;
		endcase
		return b;
	endfunction

endpackage

// ===== src/network_candidate_ranker_unit.sv =====
// Network candidate ranker. Holds up to five profile SSID tags and ranks them
// from scan reports. A start request clears every profile's best signal and
// seen flag; a report request raises the best signal of each profile whose tag
// matches; an emit request returns the profiles in use, seen profiles first by
// best signal plus position bonus (12, 6, 3, 1, 0), ties and unseen profiles in
// index order, with last set on the final one (one empty_res result when no
// profiles are in use). Requests enter a two-deep queue after tag compare, so
// the input keeps flowing while results wait. The back end pops start and
// report requests and applies them as it pops them; an emit request is popped,
// then sort keys are built, then one selection pass runs per result (the empty
// result takes one pass), each pass held while the output is stalled.
// Write configuration only while idle.
module network_candidate_ranker_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input ncr_pkg::in_req_t in_req,
	output logic out_valid,
	input logic out_stall,
	output ncr_pkg::out_res_t out_res,
	input logic cfg_we,
	input logic [ncr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ncr_pkg::TAG_W-1:0] cfg_data
);
	import ncr_pkg::*;

	logic [COUNT_W-1:0] profile_count_q;
	tag_vec_t tag_q;
	logic [COUNT_W-1:0] active_n;

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	job_t push_job;
	job_t pop_job;

	// configuration registers; out-of-range indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_count_q <= '0;
			tag_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_IDX_W'(REG_COUNT)) begin
				profile_count_q <= cfg_data[COUNT_W-1:0];
			end
			for (int i = 0; i < MAX_PROFILES; i++) begin
				if (i < NUM_TAGS && cfg_index == CFG_IDX_W'(REG_TAG0 + i)) begin
					tag_q[i] <= cfg_data;
				end
			end
		end
	end

	// saturate the profile count to what the tag registers cover
	assign active_n = (profile_count_q > COUNT_W'(ACTIVE_MAX))
		? COUNT_W'(ACTIVE_MAX) : profile_count_q;

	// front: accept requests, compare tags, drop the unused code
	ncr_front u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_req(in_req),
		.tags(tag_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_job(push_job)
	);

	// hold classified requests until the back end is free
	ncr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_job(push_job),
		.pop(q_pop),
		.pop_job(pop_job),
		.full(q_full),
		.empty(q_empty)
	);

	// back: update scan state, rank and emit results
	ncr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_job(pop_job),
		.q_pop(q_pop),
		.active_n(active_n),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res(out_res)
	);

endmodule

// ===== src/ncr_front.sv =====
module ncr_front (
	input logic in_valid,
	output logic in_stall,
	input ncr_pkg::in_req_t in_req,
	input ncr_pkg::tag_vec_t tags,
	input logic q_full,
	output logic q_push,
	output ncr_pkg::job_t q_job
);
	import ncr_pkg::*;

	logic accept;
	logic [MAX_PROFILES-1:0] hit;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;

	// compare the reported tag against every profile, used or not
	always_comb begin
		for (int i = 0; i < MAX_PROFILES; i++) begin
			hit[i] = (tags[i] == in_req.network_tag);
		end
	end

	// drop the unused command code here
	assign q_push = accept && (in_req.command != CMD_NONE);

	always_comb begin
		q_job.op = in_req.command;
		q_job.hit = hit;
		q_job.level = in_req.signal_level;
	end

endmodule

// ===== src/ncr_queue.sv =====
module ncr_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input ncr_pkg::job_t push_job,
	input logic pop,
	output ncr_pkg::job_t pop_job,
	output logic full,
	output logic empty
);
	import ncr_pkg::*;

	job_t job_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign pop_job = job_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			job_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== src/ncr_back.sv =====
module ncr_back (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input ncr_pkg::job_t q_job,
	output logic q_pop,
	input logic [ncr_pkg::COUNT_W-1:0] active_n,
	output logic out_valid,
	input logic out_stall,
	output ncr_pkg::out_res_t out_res
);
	import ncr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PREP = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q;
	logic signed [LEVEL_W-1:0] best_q [MAX_PROFILES];
	logic [MAX_PROFILES-1:0] seen_q;
	logic [MAX_PROFILES-1:0] done_q;
	logic [KEY_W-1:0] key_q [MAX_PROFILES];
	logic [COUNT_W-1:0] cnt_q;
	logic out_valid_q;
	out_res_t out_res_q;

	logic out_free;
	logic emit_go;
	logic found;
	logic [IDX_W-1:0] sel;
	logic [KEY_W-1:0] sel_key;
	logic [KEY_W-2:0] score [MAX_PROFILES];

	assign out_valid = out_valid_q;
	assign out_res = out_res_q;
	assign out_free = !out_valid_q || !out_stall;
	assign emit_go = (state_q == ST_EMIT) && out_free;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	// biased score: best + 128 + bonus, always non-negative
	always_comb begin
		for (int i = 0; i < MAX_PROFILES; i++) begin
			score[i] = {1'b0, ~best_q[i][LEVEL_W-1], best_q[i][LEVEL_W-2:0]}
				+ (KEY_W-1)'(recency_bonus(i));
		end
	end

	// pick the highest key among profiles still to emit, lowest index on ties
	always_comb begin
		found = 1'b0;
		sel = '0;
		sel_key = '0;
		for (int i = 0; i < MAX_PROFILES; i++) begin
			if ((COUNT_W'(i) < active_n) && !done_q[i]
				&& (!found || key_q[i] > sel_key)) begin
				found = 1'b1;
				sel = IDX_W'(i);
				sel_key = key_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q <= '0;
			done_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_res_q <= '0;
			for (int i = 0; i < MAX_PROFILES; i++) begin
				best_q[i] <= -8'sd128;
			end
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_job.op)
							CMD_START: begin
								seen_q <= '0;
								for (int i = 0; i < MAX_PROFILES; i++) begin
									best_q[i] <= -8'sd128;
								end
							end
							CMD_REPORT: begin
								for (int i = 0; i < MAX_PROFILES; i++) begin
									if (q_job.hit[i]) begin
										seen_q[i] <= 1'b1;
										if (q_job.level > best_q[i]) begin
											best_q[i] <= q_job.level;
										end
									end
								end
							end
							CMD_EMIT: state_q <= ST_PREP;
							default: ;
						endcase
					end
				end
				ST_PREP: begin
					done_q <= '0;
					cnt_q <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (active_n == '0) begin
							out_res_q.prof_pos <= '0;
							out_res_q.is_seen <= 1'b0;
							out_res_q.last <= 1'b1;
							out_res_q.empty_res <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							out_res_q.prof_pos <= OUT_IDX_W'(sel);
							out_res_q.is_seen <= seen_q[sel];
							out_res_q.last <= (cnt_q == active_n - COUNT_W'(1));
							out_res_q.empty_res <= 1'b0;
							done_q[sel] <= 1'b1;
							cnt_q <= cnt_q + COUNT_W'(1);
							if (cnt_q == active_n - COUNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sort keys: seen flag above the score, unseen profiles all tie at zero
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			for (int i = 0; i < MAX_PROFILES; i++) begin
				key_q[i] <= seen_q[i] ? {1'b1, score[i]} : '0;
			end
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import ncr_pkg::*;

	localparam int CLK_HALF = 10;
	localparam int CLK_PERIOD = 2 * CLK_HALF;
	localparam int RESET_CYCLES = 10;
	// slowest emit is five results after popping and sorting; leave slack for the queue
	localparam int DRAIN_TAIL = 16;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int TIMEOUT_CYCLES = 200_000;
	localparam int ITEMS_PER_PHASE = 14;

	// recency bonus by profile position, most recent first
	localparam int POS_BONUS [MAX_PROFILES] = '{12, 6, 3, 1, 0};
	localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = {1'b1, {(LEVEL_W-1){1'b0}}};

	// tags for the directed ranking: one shared by two profiles, one never matched
	localparam logic [TAG_W-1:0] TAG_SHARED = 32'h8000_0001;
	localparam logic [TAG_W-1:0] TAG_LONE = 32'h7FFF_FFFE;
	localparam logic [TAG_W-1:0] TAG_STRAY = 32'h1234_5678;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_req_t in_req;
	logic out_valid;
	logic out_stall = 1'b0;
	out_res_t out_res;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TAG_W-1:0] cfg_data;

	// predictor copy of the registers and the scan state
	logic [COUNT_W-1:0] prof_count;
	tag_vec_t prof_tag;
	logic signed [LEVEL_W-1:0] best_level [MAX_PROFILES];
	logic [MAX_PROFILES-1:0] seen_mask;

	out_res_t expected_ranks [$];

	int send_gap_max = 4;
	int rx_stall_max = 4;
	int stall_left = 0;
	logic rx_hold = 1'b0;
	event rx_hold_ev;

	int req_cnt = 0;
	int emit_cnt = 0;
	int rank_cnt = 0;
	int mismatch_cnt = 0;

	network_candidate_ranker_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res(out_res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void clear_scan_state();
		seen_mask = '0;
		for (int i = 0; i < MAX_PROFILES; i++) best_level[i] = LEVEL_FLOOR;
	endfunction

	function automatic int rank_score(input int p);
		return int'(best_level[p]) + POS_BONUS[p];
	endfunction

	// seen profiles lead; among them higher score, then lower position
	function automatic bit ranks_ahead(input int a, input int b);
		if (seen_mask[a] != seen_mask[b]) return seen_mask[a];
		// unseen profiles keep index order
		if (!seen_mask[a]) return a < b;
		if (rank_score(a) != rank_score(b)) return rank_score(a) > rank_score(b);
		return a < b;
	endfunction

	function automatic void predict_ranking();
		int order [ACTIVE_MAX];
		int n;
		int j;
		out_res_t r;
		// counts above the number of tag registers saturate
		n = (int'(prof_count) > ACTIVE_MAX) ? ACTIVE_MAX : int'(prof_count);
		r = '0;
		if (n == 0) begin
			r.last = 1'b1;
			r.empty_res = 1'b1;
			expected_ranks.push_back(r);
			return;
		end
		// stable insertion sort of positions
		for (int i = 0; i < n; i++) begin
			j = i;
			while (j > 0 && ranks_ahead(i, order[j-1])) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		for (int i = 0; i < n; i++) begin
			r.prof_pos = OUT_IDX_W'(order[i]);
			r.is_seen = seen_mask[order[i]];
			r.last = (i == n - 1);
			r.empty_res = 1'b0;
			expected_ranks.push_back(r);
		end
	endfunction

	// advance the predictor by one accepted request
	function automatic void track_request(input in_req_t r);
		req_cnt++;
		case (r.command)
			CMD_START: clear_scan_state();
			CMD_REPORT: begin
				// every profile is compared, in use or not
				for (int i = 0; i < MAX_PROFILES; i++) begin
					if (prof_tag[i] == r.network_tag) begin
						seen_mask[i] = 1'b1;
						if (r.signal_level > best_level[i]) best_level[i] = r.signal_level;
					end
				end
			end
			CMD_EMIT: begin
				emit_cnt++;
				predict_ranking();
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- drivers

	// Offer one request after a random gap; return once it has been accepted.
	// Valid stays high after acceptance so back-to-back requests never drop it.
	task automatic send_req(input logic [1:0] cmd, input logic [TAG_W-1:0] tag,
			input logic [LEVEL_W-1:0] lvl);
		int gap;
		in_req_t r;
		gap = $urandom_range(0, send_gap_max);
		r.command = cmd;
		r.network_tag = tag;
		r.signal_level = lvl;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_req <= r;
		do @(posedge clk); while (in_stall);
		track_request(r);
	endtask

	task automatic write_reg(input int idx, input logic [TAG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= val;
		@(posedge clk);
		// indexes past the last tag register are dropped by the block
		if (idx == REG_COUNT) begin
			prof_count = val[COUNT_W-1:0];
		end else if (idx >= REG_TAG0 && idx < REG_TAG0 + NUM_TAGS) begin
			prof_tag[idx - REG_TAG0] = val;
		end
	endtask

	task automatic finish_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_profiles(input logic [COUNT_W-1:0] cnt, input tag_vec_t tags);
		write_reg(REG_COUNT, TAG_W'(cnt));
		for (int i = 0; i < NUM_TAGS; i++) write_reg(REG_TAG0 + i, tags[i]);
		finish_writes();
	endtask

	// Drop valid, wait for every expected result, then let the back end settle
	// so that queued start and report requests have retired too.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_ranks.size() != 0) @(negedge clk);
		repeat (DRAIN_TAIL) @(negedge clk);
	endtask

	// ---------------------------------------------------------------- receiver

	// hold the output off per result, plus the long hold when requested
	always @(negedge clk) begin
		out_stall <= rx_hold || (stall_left != 0);
		if (stall_left != 0) stall_left--;
	end

	// long receiver hold, counted on rising edges so the driver above reads a settled flag
	initial begin
		forever begin
			@(rx_hold_ev);
			@(posedge clk);
			rx_hold = 1'b1;
			repeat (RX_HOLD_CYCLES) @(posedge clk);
			rx_hold = 1'b0;
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	// compare each accepted result with the oldest expected rank
	always @(posedge clk) begin : check_ranks
		out_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			rank_cnt++;
			stall_left = $urandom_range(0, rx_stall_max);
			if (expected_ranks.size() == 0) begin
				$display("%0t unexpected result: index %0d seen %0d last %0d empty %0d",
					$time, out_res.prof_pos, out_res.is_seen, out_res.last,
					out_res.empty_res);
				mismatch_cnt++;
			end else begin
				want = expected_ranks.pop_front();
				check_field("prof_pos", int'(want.prof_pos), int'(out_res.prof_pos));
				check_field("is_seen", int'(want.is_seen), int'(out_res.is_seen));
				check_field("last", int'(want.last), int'(out_res.last));
				check_field("empty_res", int'(want.empty_res), int'(out_res.empty_res));
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// no profiles in use: one empty result per emit; the unused code does nothing
	task automatic test_empty_profiles();
		send_req(CMD_EMIT, '0, '0);
		send_req(CMD_NONE, '1, '1);
		send_req(CMD_EMIT, '1, '1);
		wait_idle();
	endtask

	// reports update profiles beyond the count, visible once the count grows
	task automatic test_unused_profiles_tracked();
		send_req(CMD_REPORT, '0, 8'sd50);
		send_req(CMD_EMIT, '0, '0);
		wait_idle();
		write_reg(REG_COUNT, TAG_W'(MAX_PROFILES));
		finish_writes();
		send_req(CMD_EMIT, '0, '0);
		wait_idle();
	endtask

	// extreme tags and levels, a tag shared by two profiles, an exact tie,
	// an unseen profile, repeated emits and a fresh start
	task automatic test_directed_ranking();
		set_profiles(COUNT_W'(MAX_PROFILES),
			{TAG_LONE, TAG_SHARED, TAG_SHARED, 32'hFFFF_FFFF, 32'h0});
		send_req(CMD_START, '0, '0);
		send_req(CMD_REPORT, 32'h0, -8'sd20);
		send_req(CMD_REPORT, 32'hFFFF_FFFF, -8'sd14);
		send_req(CMD_REPORT, TAG_SHARED, 8'sd127);
		send_req(CMD_REPORT, TAG_SHARED, LEVEL_FLOOR);
		send_req(CMD_REPORT, TAG_STRAY, 8'sd127);
		send_req(CMD_NONE, TAG_LONE, 8'sd100);
		send_req(CMD_EMIT, '0, '0);
		send_req(CMD_EMIT, '1, '1);
		send_req(CMD_REPORT, TAG_LONE, LEVEL_FLOOR);
		send_req(CMD_EMIT, '0, '0);
		send_req(CMD_START, '1, '1);
		send_req(CMD_EMIT, '0, '0);
		wait_idle();
	endtask

	// saturated counts, a single profile, and writes past the last register
	task automatic test_count_limits();
		send_req(CMD_REPORT, TAG_SHARED, 8'sd10);
		wait_idle();
		write_reg(REG_COUNT, 32'd7);
		finish_writes();
		send_req(CMD_EMIT, '0, '0);
		wait_idle();
		write_reg(REG_COUNT, 32'd6);
		finish_writes();
		send_req(CMD_EMIT, '0, '0);
		wait_idle();
		write_reg(REG_COUNT, 32'd1);
		finish_writes();
		send_req(CMD_EMIT, '0, '0);
		wait_idle();
		write_reg(REG_COUNT, 32'd3);
		write_reg(REG_TAG0 + NUM_TAGS, $urandom);
		write_reg(REG_TAG0 + NUM_TAGS + 1, $urandom);
		finish_writes();
		send_req(CMD_EMIT, '0, '0);
		wait_idle();
	endtask

	// one scan: mostly start, matching reports, emit; with stray and broken requests
	task automatic scan_round();
		int nrep;
		if ($urandom_range(0, 7) != 0) send_req(CMD_START, $urandom, LEVEL_W'($urandom));
		nrep = $urandom_range(0, 6);
		repeat (nrep) begin
			case ($urandom_range(0, 9))
				0: send_req(CMD_NONE, $urandom, LEVEL_W'($urandom));
				1: send_req(CMD_REPORT, $urandom, LEVEL_W'($urandom));
				2: send_req(2'($urandom_range(0, 3)), $urandom, LEVEL_W'($urandom));
				default: send_req(CMD_REPORT,
					prof_tag[IDX_W'($urandom_range(0, MAX_PROFILES - 1))],
					LEVEL_W'($urandom));
			endcase
		end
		send_req(CMD_EMIT, $urandom, LEVEL_W'($urandom));
		if ($urandom_range(0, 3) == 0) send_req(CMD_EMIT, $urandom, LEVEL_W'($urandom));
	endtask

	task automatic test_random_scans();
		logic [COUNT_W-1:0] cnt;
		tag_vec_t tags;
		int start_cnt;
		for (int ph = 0; ph < 5; ph++) begin
			wait_idle();
			case (ph)
				0: begin
					// full set, no idling on either side
					cnt = COUNT_W'(MAX_PROFILES);
					send_gap_max = 0;
					rx_stall_max = 0;
				end
				1: begin
					cnt = 3'd7;
					send_gap_max = 16;
					rx_stall_max = 16;
				end
				2: begin
					cnt = '0;
					send_gap_max = 4;
					rx_stall_max = 16;
				end
				3: begin
					cnt = COUNT_W'($urandom_range(1, 4));
					send_gap_max = 16;
					rx_stall_max = 0;
				end
				default: begin
					cnt = COUNT_W'($urandom_range(0, 7));
					send_gap_max = 8;
					rx_stall_max = 8;
				end
			endcase
			// draw tags from a small pool so duplicates and extremes recur
			for (int i = 0; i < NUM_TAGS; i++) begin
				case ($urandom_range(0, 5))
					0: tags[i] = '0;
					1: tags[i] = '1;
					2, 3: tags[i] = 32'h5A5A_0000 + $urandom_range(0, 3);
					default: tags[i] = $urandom;
				endcase
			end
			set_profiles(cnt, tags);
			start_cnt = req_cnt;
			while (req_cnt - start_cnt < ITEMS_PER_PHASE) scan_round();
		end
		wait_idle();
	endtask

	// hold the output for a long stretch while requests keep coming
	task automatic test_output_backpressure();
		tag_vec_t tags;
		for (int i = 0; i < NUM_TAGS; i++) tags[i] = $urandom;
		set_profiles(COUNT_W'(MAX_PROFILES), tags);
		send_gap_max = 0;
		rx_stall_max = 2;
		send_req(CMD_START, '0, '0);
		-> rx_hold_ev;
		repeat (12) begin
			send_req(CMD_REPORT, prof_tag[IDX_W'($urandom_range(0, MAX_PROFILES - 1))],
				LEVEL_W'($urandom));
			send_req(CMD_EMIT, $urandom, LEVEL_W'($urandom));
		end
		wait_idle();
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		prof_count = '0;
		prof_tag = '0;
		clear_scan_state();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_profiles();
		test_unused_profiles_tracked();
		test_directed_ranking();
		test_count_limits();
		test_random_scans();
		test_output_backpressure();
		wait_idle();

		$display("Sent %0d requests including %0d emits; checked %0d ranked results.",
			req_cnt, emit_cnt, rank_cnt);
		$display("Profile counts 0 to 7, shared and extreme tags, full signal range, "
			, "output held %0d cycles; %0d mismatches.", RX_HOLD_CYCLES, mismatch_cnt);
		if (mismatch_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("TB_ERROR");
		$finish;
	end

endmodule
